### rtl/cemp_pkg.sv
`timescale 1ns / 1ps

package cemp_pkg;

   // field widths
   localparam int TICK_W = 12;
   localparam int TIME_W = 16;
   localparam int Q16_W  = 17;

   // ease table size and index width
   localparam int EASE_TABLE_STEPS = 256;
   localparam int EASE_HALF_STEPS  = EASE_TABLE_STEPS / 2;
   localparam int EASE_IDX_W       = $clog2(EASE_TABLE_STEPS + 1);

   // one quotient bit per divider stage
   localparam int DIV_STAGES = TIME_W;

   // goal limit used when both limit registers are zero
   localparam logic [TICK_W-1:0] DEFAULT_MAX_TICKS = 12'd3414;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LIMIT_MAX = 2'd1;

   // fixed-point constants of the cosine series
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint          ONE_Q30 = 64'sd1073741824;
   localparam int              TAYLOR_TERMS = 12;

   typedef logic [Q16_W-1:0] ease_tab_type [0:EASE_TABLE_STEPS];

   // beat moving through the divider: sideband plus partial remainder and quotient
   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [TICK_W-1:0] goal;
      logic              sat;
      logic [TIME_W-1:0] dur;
      logic [TIME_W-1:0] rem;
      logic [TIME_W-1:0] quo;
   } div_beat_type;

   // 0.5 - 0.5*cos(pi*i/steps) for the lower half, twelve-term Taylor series in Q30
   // each term is the previous one times theta^2 over (2k-1)(2k), signs alternate
   function automatic logic [Q16_W-1:0] ease_entry_low(int unsigned i);
      longint unsigned theta;
      longint unsigned t2;
      longint unsigned term;
      longint          sum;
      longint          diff;
      longint unsigned rounded;
      theta = (PI_Q30 * longint'(i)) / EASE_TABLE_STEPS;
      t2    = (theta * theta) >> 30;
      term  = 64'd1073741824;
      sum   = ONE_Q30;
      term  = ((term * t2) / 64'd2) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd12) >> 30;
      sum   = sum + longint'(term);
      term  = ((term * t2) / 64'd30) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd56) >> 30;
      sum   = sum + longint'(term);
      term  = ((term * t2) / 64'd90) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd132) >> 30;
      sum   = sum + longint'(term);
      term  = ((term * t2) / 64'd182) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd240) >> 30;
      sum   = sum + longint'(term);
      term  = ((term * t2) / 64'd306) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd380) >> 30;
      sum   = sum + longint'(term);
      term  = ((term * t2) / 64'd462) >> 30;
      sum   = sum - longint'(term);
      term  = ((term * t2) / 64'd552) >> 30;
      sum   = sum + longint'(term);
      diff = ONE_Q30 - sum;
      if (diff < 0) begin
         diff = 0;
      end
      rounded = (longint'(diff) + 64'd16384) >> 15;
      return rounded[Q16_W-1:0];
   endfunction

   // full table, upper half mirrored from the lower half
   function automatic ease_tab_type build_ease_tab();
      ease_tab_type tab;
      for (int i = 0; i <= EASE_TABLE_STEPS; i++) begin
         if (i <= EASE_HALF_STEPS) begin
            tab[i] = ease_entry_low(i);
         end else begin
            tab[i] = 17'h10000 - ease_entry_low(EASE_TABLE_STEPS - i);
         end
      end
      return tab;
   endfunction

   localparam ease_tab_type EASE_TAB = build_ease_tab();

endpackage

### rtl/cemp_div_pipe.sv
`timescale 1ns / 1ps

module cemp_div_pipe import cemp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  div_beat_type in_beat,
   output logic         out_valid,
   output div_beat_type out_beat
);

   logic [DIV_STAGES-1:0] valid_ff;
   div_beat_type          stage_ff [DIV_STAGES];
   div_beat_type          stage_in [DIV_STAGES];
   div_beat_type          src_beat [DIV_STAGES];

   // one restoring step: shift remainder, trial subtract, shift quotient bit in
   function automatic div_beat_type div_step(div_beat_type b);
      div_beat_type     r;
      logic [TIME_W:0]  shifted;
      logic [TIME_W:0]  trial;
      r       = b;
      shifted = {b.rem, 1'b0};
      trial   = shifted - {1'b0, b.dur};
      if (shifted >= {1'b0, b.dur}) begin
         r.rem = trial[TIME_W-1:0];
         r.quo = {b.quo[TIME_W-2:0], 1'b1};
      end else begin
         r.rem = shifted[TIME_W-1:0];
         r.quo = {b.quo[TIME_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // stage sources
   always_comb begin
      src_beat[0] = in_beat;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src_beat[k] = stage_ff[k-1];
      end
   end

   // per-stage step logic
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         stage_in[k] = div_step(src_beat[k]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_beat  = stage_ff[DIV_STAGES-1];

endmodule

### rtl/cosine_eased_motion_profile.sv
`timescale 1ns / 1ps

// Cosine-eased point-to-point position command for one servo axis.
// Request beat: start position, requested goal, elapsed and total move time.
// Response beat: position command and a done flag once the move time is up.
// The goal is clamped to limit_min..limit_max (0..3414 while both are zero);
// the limits are written on the csr channel (index 0 min, 1 max); the user must
// write them only while idle (the block does not enforce it); csr_ready is always high.
// Pipeline: a response passes an input register, a 16-stage divider with one
// quotient bit per stage, then table lookup, interpolation multiply,
// interpolation add, the scaling multiply and the output register.
// Throughput: one beat per cycle, any mix of items, no dependence between them.
// When the receiver stalls the whole pipeline holds; the input register
// still takes one more beat if it is empty, then req_ready drops.
// Reset clears all valid bits and sets both limits to zero.
module cosine_eased_motion_profile import cemp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TICK_W-1:0]      req_start_ticks,
   input  logic [TICK_W-1:0]      req_goal_ticks,
   input  logic [TIME_W-1:0]      req_elapsed_ms,
   input  logic [TIME_W-1:0]      req_duration_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TICK_W-1:0]      rsp_command_ticks,
   output logic                   rsp_done_res,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_data
);

   localparam int P_W = Q16_W + EASE_IDX_W;
   localparam int I_W = P_W - 16;

   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [TICK_W-1:0] absd;
      logic              neg;
      logic              done;
   } side_type;

   logic [TICK_W-1:0] limit_min_ff;
   logic [TICK_W-1:0] limit_max_ff;

   logic              advance;
   logic              s0_load;
   logic              s0_valid_ff;
   div_beat_type      s0_beat_ff;
   div_beat_type      s0_beat_in;

   logic              dv_valid;
   div_beat_type      dv_beat;

   logic              e1_valid_ff, e2_valid_ff, e3_valid_ff, e4_valid_ff;
   side_type          e1_side_ff, e2_side_ff, e3_side_ff, e4_side_ff;
   side_type          e1_side_in;
   logic [Q16_W-1:0]  e1_t0_ff, e1_t0_in, e2_t0_ff;
   logic signed [Q16_W:0] e1_diff_ff, e1_diff_in;
   logic [15:0]       e1_f_ff;
   logic signed [2*Q16_W:0] e2_mul_ff;
   logic signed [35:0] e3_sum;
   logic [Q16_W-1:0]  e3_ease_ff;
   logic [TICK_W+Q16_W-1:0] e4_prod_ff;

   logic [Q16_W-1:0]  u_q;
   logic [P_W-1:0]    p_q;
   logic [I_W-1:0]    idx;
   logic [EASE_IDX_W-1:0] idx_lo, idx_hi;
   logic [TICK_W-1:0] clamp_hi;
   logic [TICK_W:0]   delta;
   logic [TICK_W+Q16_W-1:0] rnd;
   logic [TICK_W:0]   mag;
   logic [TICK_W-1:0] cmd_in;

   logic              out_valid_ff;
   logic [TICK_W-1:0] out_cmd_ff;
   logic              out_done_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_min_ff <= '0;
         limit_max_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_LIMIT_MIN) begin
            limit_min_ff <= csr_data;
         end
         if (csr_index == REG_LIMIT_MAX) begin
            limit_max_ff <= csr_data;
         end
      end
   end

   // pipeline moves whenever the output slot is free or being taken
   assign advance   = !out_valid_ff || rsp_ready;
   assign s0_load   = !s0_valid_ff || advance;
   assign req_ready = s0_load;

   // goal clamp and saturation check ahead of the input register
   always_comb begin
      clamp_hi = (limit_min_ff == '0 && limit_max_ff == '0) ? DEFAULT_MAX_TICKS
                                                              : limit_max_ff;
      s0_beat_in.start = req_start_ticks;
      if (req_goal_ticks < limit_min_ff) begin
         s0_beat_in.goal = limit_min_ff;
      end else if (req_goal_ticks > clamp_hi) begin
         s0_beat_in.goal = clamp_hi;
      end else begin
         s0_beat_in.goal = req_goal_ticks;
      end
      s0_beat_in.sat = (req_duration_ms == '0) || (req_elapsed_ms >= req_duration_ms);
      s0_beat_in.dur = req_duration_ms;
      s0_beat_in.rem = req_elapsed_ms;
      s0_beat_in.quo = '0;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_load) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load && req_valid) begin
         s0_beat_ff <= s0_beat_in;
      end
   end

   // progress = elapsed / duration in Q0.16
   cemp_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_beat   (s0_beat_ff),
      .out_valid (dv_valid),
      .out_beat  (dv_beat)
   );

   // table lookup of both neighbors and the move delta
   always_comb begin
      u_q    = dv_beat.sat ? 17'h10000 : {1'b0, dv_beat.quo};
      p_q    = P_W'(u_q) * P_W'(EASE_TABLE_STEPS);
      idx    = p_q[P_W-1:16];
      idx_lo = idx[EASE_IDX_W-1:0];
      idx_hi = idx_lo + 1'b1;
      if (idx >= I_W'(EASE_TABLE_STEPS)) begin
         e1_t0_in   = EASE_TAB[EASE_TABLE_STEPS];
         e1_diff_in = '0;
      end else begin
         e1_t0_in   = EASE_TAB[idx_lo];
         e1_diff_in = $signed({1'b0, EASE_TAB[idx_hi]}) - $signed({1'b0, EASE_TAB[idx_lo]});
      end
      delta            = {1'b0, dv_beat.goal} - {1'b0, dv_beat.start};
      e1_side_in.start = dv_beat.start;
      e1_side_in.neg   = delta[TICK_W];
      e1_side_in.absd  = delta[TICK_W] ? TICK_W'(-delta) : delta[TICK_W-1:0];
      e1_side_in.done  = dv_beat.sat;
   end

   // interpolation: t0*65536 + (t1-t0)*f, rounded
   assign e3_sum = $signed({3'b000, e2_t0_ff, 16'h0000}) + 36'(e2_mul_ff) + 36'sd32768;

   // scaled delta rounded half away from zero, then applied to start
   always_comb begin
      rnd    = e4_prod_ff + (TICK_W+Q16_W)'(32768);
      mag    = rnd[TICK_W+Q16_W-1:16];
      cmd_in = e4_side_ff.neg ? (e4_side_ff.start - mag[TICK_W-1:0])
                              : (e4_side_ff.start + mag[TICK_W-1:0]);
   end

   // tail valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         e4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         e1_valid_ff  <= dv_valid;
         e2_valid_ff  <= e1_valid_ff;
         e3_valid_ff  <= e2_valid_ff;
         e4_valid_ff  <= e3_valid_ff;
         out_valid_ff <= e4_valid_ff;
      end
   end

   // tail payload
   always_ff @(posedge clock) begin
      if (advance) begin
         e1_t0_ff    <= e1_t0_in;
         e1_diff_ff  <= e1_diff_in;
         e1_f_ff     <= p_q[15:0];
         e1_side_ff  <= e1_side_in;
         e2_t0_ff    <= e1_t0_ff;
         e2_mul_ff   <= e1_diff_ff * $signed({1'b0, e1_f_ff});
         e2_side_ff  <= e1_side_ff;
         e3_ease_ff  <= e3_sum[32:16];
         e3_side_ff  <= e2_side_ff;
         e4_prod_ff  <= (TICK_W+Q16_W)'(e3_side_ff.absd) * (TICK_W+Q16_W)'(e3_ease_ff);
         e4_side_ff  <= e3_side_ff;
         out_cmd_ff  <= cmd_in;
         out_done_ff <= e4_side_ff.done;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_command_ticks = out_cmd_ff;
   assign rsp_done_res      = out_done_ff;

endmodule

### tb/sv/motion_command_checker.sv
`timescale 1ns / 1ps

// watches all three channels, predicts each command beat and compares
module motion_command_checker import cemp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [TICK_W-1:0]      req_start_ticks,
   input  logic [TICK_W-1:0]      req_goal_ticks,
   input  logic [TIME_W-1:0]      req_elapsed_ms,
   input  logic [TIME_W-1:0]      req_duration_ms,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [TICK_W-1:0]      rsp_command_ticks,
   input  logic                   rsp_done_res,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]      csr_data,
   output int                     mismatches,
   output int                     outstanding
);

   localparam longint unsigned UNITY_Q16 = 64'd65536;

   typedef struct packed {
      logic [TICK_W-1:0] command;
      logic              done;
   } motion_beat_type;

   longint unsigned   ease_q16 [0:EASE_TABLE_STEPS];
   logic [TICK_W-1:0] limit_lo = '0;
   logic [TICK_W-1:0] limit_hi = '0;
   motion_beat_type   expected_moves [$];
   int                error_total = 0;

   // rising half of 0.5 - 0.5*cos, truncated series in Q30, rounded to Q16
   function automatic longint unsigned rise_low_half(int unsigned step);
      longint unsigned angle;
      longint unsigned angle_sq;
      longint unsigned term;
      longint          series;
      longint          lift;
      angle    = (PI_Q30 * 64'(step)) / 64'(EASE_TABLE_STEPS);
      angle_sq = (angle * angle) >> 30;
      term     = 64'd1 << 30;
      series   = ONE_Q30;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = ((term * angle_sq) / 64'((2 * k - 1) * (2 * k))) >> 30;
         if (k % 2 == 1) begin
            series = series - longint'(term);
         end else begin
            series = series + longint'(term);
         end
      end
      lift = ONE_Q30 - series;
      if (lift < 0) begin
         lift = 0;
      end
      return (64'(lift) + 64'd16384) >> 15;
   endfunction

   // upper half of the table mirrors the lower half
   initial begin
      for (int i = 0; i <= EASE_TABLE_STEPS; i++) begin
         if (i <= EASE_TABLE_STEPS / 2) begin
            ease_q16[i] = rise_low_half(i);
         end else begin
            ease_q16[i] = UNITY_Q16 - rise_low_half(EASE_TABLE_STEPS - i);
         end
      end
   end

   // position command and done flag for one request under the current limits
   function automatic motion_beat_type predict_motion(
      input logic [TICK_W-1:0] start,
      input logic [TICK_W-1:0] goal_req,
      input logic [TIME_W-1:0] elapsed,
      input logic [TIME_W-1:0] duration
   );
      logic [TICK_W-1:0] lo;
      logic [TICK_W-1:0] hi;
      logic [TICK_W-1:0] goal;
      longint unsigned   progress;
      longint unsigned   scaled;
      longint unsigned   idx;
      longint unsigned   frac;
      longint unsigned   ease;
      longint unsigned   span;
      longint unsigned   mag;
      longint            delta;
      longint            cmd;
      motion_beat_type   beat;
      // goal clamp, default range while both limits are zero
      lo = limit_lo;
      hi = limit_hi;
      if (lo == '0 && hi == '0) begin
         hi = DEFAULT_MAX_TICKS;
      end
      if (goal_req < lo) begin
         goal = lo;
      end else if (goal_req > hi) begin
         goal = hi;
      end else begin
         goal = goal_req;
      end
      // progress in Q0.16, saturating at one
      if (duration == '0) begin
         progress = UNITY_Q16;
      end else begin
         progress = (64'(elapsed) << 16) / 64'(duration);
         if (progress > UNITY_Q16) begin
            progress = UNITY_Q16;
         end
      end
      // table lookup with linear interpolation
      scaled = progress * 64'(EASE_TABLE_STEPS);
      idx    = scaled >> 16;
      frac   = scaled & 64'hFFFF;
      if (idx >= 64'(EASE_TABLE_STEPS)) begin
         ease = ease_q16[EASE_TABLE_STEPS];
      end else begin
         ease = (ease_q16[idx] * (UNITY_Q16 - frac) + ease_q16[idx + 1] * frac
                 + 64'd32768) >> 16;
      end
      // scale the move, rounding half away from zero
      delta = $signed({1'b0, goal}) - $signed({1'b0, start});
      span  = (delta < 0) ? 64'(-delta) : 64'(delta);
      mag   = (span * ease + 64'd32768) >> 16;
      cmd   = (delta < 0) ? longint'(start) - longint'(mag)
                          : longint'(start) + longint'(mag);
      beat.command = cmd[TICK_W-1:0];
      beat.done    = (progress >= UNITY_Q16);
      return beat;
   endfunction

   always @(posedge clock) begin
      motion_beat_type want;
      if (reset) begin
         limit_lo = '0;
         limit_hi = '0;
         expected_moves.delete();
      end else begin
         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               error_total++;
               $display("%0t motion check: unexpected beat, expected none, got command %0d done %0d",
                        $time, rsp_command_ticks, rsp_done_res);
            end else begin
               want = expected_moves.pop_front();
               if (rsp_command_ticks !== want.command) begin
                  error_total++;
                  $display("%0t motion check: command_ticks expected %0d, got %0d",
                           $time, want.command, rsp_command_ticks);
               end
               if (rsp_done_res !== want.done) begin
                  error_total++;
                  $display("%0t motion check: done_res expected %0d, got %0d",
                           $time, want.done, rsp_done_res);
               end
            end
         end
         // limit register writes, unmapped indexes dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LIMIT_MIN: limit_lo = csr_data;
               REG_LIMIT_MAX: limit_hi = csr_data;
               default: ;
            endcase
         end
         // new request beat, appended behind the older predictions
         if (req_valid && req_ready) begin
            expected_moves = {expected_moves,
                              predict_motion(req_start_ticks, req_goal_ticks,
                                             req_elapsed_ms, req_duration_ms)};
         end
      end
      mismatches  <= error_total;
      outstanding <= expected_moves.size();
   end

endmodule

### tb/sv/cosine_eased_motion_profile_tb.sv
`timescale 1ns / 1ps

module cosine_eased_motion_profile_tb;
   import cemp_pkg::*;

   localparam int IDLE_LIMIT      = 4000;
   localparam int MOVES_PER_PHASE = 125;
   localparam int PHASES          = 8;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TICK_W-1:0]      req_start_ticks = '0;
   logic [TICK_W-1:0]      req_goal_ticks = '0;
   logic [TIME_W-1:0]      req_elapsed_ms = '0;
   logic [TIME_W-1:0]      req_duration_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TICK_W-1:0]      rsp_command_ticks;
   logic                   rsp_done_res;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_LIMIT_MIN;
   logic [TICK_W-1:0]      csr_data = '0;
   int                     mismatches;
   int                     outstanding;
   int                     idle_cycles = 0;
   int                     moves_sent = 0;
   int                     beats_taken = 0;

   always #10 clock = ~clock;

   cosine_eased_motion_profile DUT (.*);

   motion_command_checker u_command_check (.*);

   // one request beat, after a random gap unless in a back-to-back stretch
   task automatic offer_move(input logic [TICK_W-1:0] start, input logic [TICK_W-1:0] goal,
                             input logic [TIME_W-1:0] elapsed,
                             input logic [TIME_W-1:0] duration);
      int gap;
      gap = ((moves_sent % 100) < 15) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_ticks <= start;
      req_goal_ticks  <= goal;
      req_elapsed_ms  <= elapsed;
      req_duration_ms <= duration;
      do @(posedge clock); while (!req_ready);
      moves_sent++;
   endtask

   // stop offering and wait until every command beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write an unmapped index, then both limits, back to back
   task automatic program_limits(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi,
                                 input logic [CSR_INDEX_W-1:0] spare);
      logic [CSR_INDEX_W-1:0] idx [3];
      logic [TICK_W-1:0]      val [3];
      idx = '{spare, REG_LIMIT_MIN, REG_LIMIT_MAX};
      val = '{TICK_W'($urandom), lo, hi};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [TICK_W-1:0] phase_lo [PHASES];
      logic [TICK_W-1:0] phase_hi [PHASES];
      logic [TICK_W-1:0] start;
      logic [TICK_W-1:0] goal;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] duration;
      int                kind;
      phase_lo = '{12'd0, 12'd0, 12'd4095, 12'd4095, 12'd1, 12'd3000,
                   TICK_W'($urandom), TICK_W'($urandom)};
      phase_hi = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd4094, 12'd1000,
                   TICK_W'($urandom), TICK_W'($urandom)};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default limits: move start, midpoint, reverse moves, jumps, saturation
      offer_move(12'd0, 12'd4095, 16'd0, 16'd1000);
      offer_move(12'd0, 12'd3414, 16'd500, 16'd1000);
      offer_move(12'd4095, 12'd0, 16'd250, 16'd1000);
      offer_move(12'd100, 12'd4095, 16'd0, 16'd0);
      offer_move(12'd3000, 12'd5, 16'd65535, 16'd0);
      offer_move(12'd17, 12'd2000, 16'd65535, 16'd1);
      offer_move(12'd4095, 12'd4095, 16'd65535, 16'd65535);
      offer_move(12'd0, 12'd3414, 16'd1, 16'd65535);
      offer_move(12'd3414, 12'd0, 16'd65534, 16'd65535);
      offer_move(12'd1234, 12'd1234, 16'd300, 16'd700);
      offer_move(12'd0, 12'd3414, 16'd1, 16'd3);
      offer_move(12'd2048, 12'd4095, 16'd32768, 16'd65535);
      settle();

      // crossed limits: low goals pinned to the minimum, the rest to the maximum
      program_limits(12'd3000, 12'd1000, REG_SPARE_A);
      offer_move(12'd0, 12'd0, 16'd10, 16'd20);
      offer_move(12'd4095, 12'd2999, 16'd10, 16'd20);
      offer_move(12'd0, 12'd3000, 16'd0, 16'd0);
      offer_move(12'd4095, 12'd4095, 16'd20, 16'd20);
      settle();

      // random phases, one limit setting each
      for (int p = 0; p < PHASES; p++) begin
         program_limits(phase_lo[p], phase_hi[p], (p % 2 == 0) ? REG_SPARE_B : REG_SPARE_A);
         for (int n = 0; n < MOVES_PER_PHASE; n++) begin
            start = TICK_W'($urandom);
            goal  = ($urandom_range(0, 9) == 0) ? start : TICK_W'($urandom);
            kind  = $urandom_range(0, 9);
            case (kind)
               0: begin
                  duration = '0;
                  elapsed  = TIME_W'($urandom);
               end
               1: begin
                  duration = TIME_W'($urandom_range(1, 65534));
                  elapsed  = TIME_W'($urandom_range(duration + 1, 65535));
               end
               2: begin
                  duration = TIME_W'($urandom_range(1, 64));
                  elapsed  = TIME_W'($urandom_range(0, duration));
               end
               3: begin
                  duration = TIME_W'($urandom);
                  elapsed  = TIME_W'($urandom);
               end
               default: begin
                  duration = TIME_W'($urandom_range(1, 65535));
                  elapsed  = TIME_W'($urandom_range(0, duration));
               end
            endcase
            offer_move(start, goal, elapsed, duration);
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("cosine_eased_motion_profile_tb: done, clean");
      end else begin
         $display("cosine_eased_motion_profile_tb: done, errors");
      end
      $finish;
   end

   // receiver: random stall per beat, two long holds that back up the pipeline
   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (beats_taken == 150 || beats_taken == 640) begin
            stall = RSP_HOLD_CYCLES;
         end else if ((beats_taken % 100) < 20) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats_taken++;
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("cosine_eased_motion_profile_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
